// ===== hdl/rgb_row_filter_with_mirror_top_macros.svh =====
// Assertion macros for the row filter. Both sample on clk and are off during rst.
`ifndef RGB_ROW_FILTER_WITH_MIRROR_TOP_MACROS_SVH
`define RGB_ROW_FILTER_WITH_MIRROR_TOP_MACROS_SVH

`define RRFM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define RRFM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rrfm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rrfm_pkg;

  localparam int CH_W = 8;
  localparam int RW_W = 7;
  localparam int IDX_W = 3;

  // Division by three as a multiply by a reciprocal; exact for sums below 2048.
  localparam int GREY_RECIP = 683;
  localparam int GREY_SHIFT = 11;
  localparam int SUM_W = CH_W + 2;
  localparam int PROD_W = SUM_W + GREY_SHIFT;

  localparam logic [IDX_W-1:0] CFG_CHAN_LIMIT = 3'd0;
  localparam logic [IDX_W-1:0] CFG_ROW_WIDTH = 3'd1;
  localparam logic [IDX_W-1:0] CFG_GREY_ENABLE = 3'd2;
  localparam logic [IDX_W-1:0] CFG_MIRROR_ENABLE = 3'd3;
  localparam logic [IDX_W-1:0] CFG_NEGATE_MASK = 3'd4;
  localparam logic [IDX_W-1:0] CFG_KEEP_ONLY_MASK = 3'd5;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            row_end;
  } pix_out_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic   mirror;
    logic   last;
    pixel_t px;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_WAIT
  } back_state_t;

endpackage

`default_nettype wire

// ===== hdl/rgb_row_filter_with_mirror_top.sv =====
// A pixel passed straight through goes from the command queue into the output register.
// Unmirrored throughput: one word per cycle unless out_stall, set by the queue and output register.
// A mirrored row follows its last pixel; each word is read from RAM in BK_FETCH, output in BK_WAIT.
// Input stalls while a reversed row is read out of the line store.
// Reset (synchronous, active high) clears control and loads register defaults;
// the line store is not cleared and holds no valid bits.
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_row_filter_with_mirror_top_macros.svh"

module rgb_row_filter_with_mirror_top #(
  parameter int MAX_WIDTH = 64,
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [rrfm_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [rrfm_pkg::CH_W-1:0]   cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire rrfm_pkg::pix_in_t           in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output rrfm_pkg::pix_out_t               out_data
);

  import rrfm_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int FIFO_W = $bits(cmd_t) + CW;

  logic              fifo_full;
  logic              fifo_empty;
  logic              push;
  logic              pop;
  cmd_t              front_cmd;
  logic [CW-1:0]     front_col;
  cmd_t              back_cmd;
  logic [CW-1:0]     back_col;
  logic [FIFO_W-1:0] fifo_rd;
  logic              ram_wr_en;
  logic [CW-1:0]     ram_wr_addr;
  pixel_t            ram_wr_data;
  logic [CW-1:0]     ram_rd_addr;
  pixel_t            ram_rd_data;
  logic              back_busy;
  logic              back_done;

  assign cfg_ready = 1'b1;

  rrfm_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_data(in_data),
    .in_stall(in_stall),
    .fifo_full(fifo_full),
    .back_done(back_done),
    .push(push),
    .cmd(front_cmd),
    .cmd_col(front_col),
    .ram_wr_en(ram_wr_en),
    .ram_wr_addr(ram_wr_addr),
    .ram_wr_data(ram_wr_data)
  );

  rrfm_fifo #(
    .WIDTH(FIFO_W),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wr_data({front_cmd, front_col}),
    .pop(pop),
    .rd_data(fifo_rd),
    .full(fifo_full),
    .empty(fifo_empty)
  );

  assign back_cmd = fifo_rd[FIFO_W-1:CW];
  assign back_col = fifo_rd[CW-1:0];

  rrfm_ram #(
    .WIDTH($bits(pixel_t)),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk(clk),
    .wr_en(ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  rrfm_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cmd_valid(!fifo_empty),
    .cmd(back_cmd),
    .cmd_col(back_col),
    .pop(pop),
    .ram_rd_addr(ram_rd_addr),
    .ram_rd_data(ram_rd_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .busy(back_busy),
    .done(back_done)
  );

  `RRFM_ASSERT_NOW(a_busy_blocks_input, back_busy, in_stall, "input open during row readout")
  `RRFM_ASSERT_NEXT(a_done_ends_row, back_done, out_valid && out_data.row_end,
                    "reversed row finished without row end")
  `RRFM_ASSERT_NOW(a_no_pop_when_empty, pop, !fifo_empty, "command popped from empty queue")

endmodule

`default_nettype wire

// ===== hdl/rrfm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rrfm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/rrfm_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rrfm_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rrfm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rrfm_front #(
  parameter int MAX_WIDTH = 64,
  parameter int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  input  wire logic [rrfm_pkg::IDX_W-1:0]      cfg_index,
  input  wire logic [rrfm_pkg::CH_W-1:0]       cfg_data,
  input  wire logic                            in_valid,
  input  wire rrfm_pkg::pix_in_t               in_data,
  output logic                                 in_stall,
  input  wire logic                            fifo_full,
  input  wire logic                            back_done,
  output logic                                 push,
  output rrfm_pkg::cmd_t                       cmd,
  output logic      [CW-1:0]                   cmd_col,
  output logic                                 ram_wr_en,
  output logic      [CW-1:0]                   ram_wr_addr,
  output rrfm_pkg::pixel_t                     ram_wr_data
);

  import rrfm_pkg::*;

  logic [CH_W-1:0] chan_limit;
  logic [RW_W-1:0] row_width;
  logic            grey_enable;
  logic            mirror_enable;
  logic [2:0]      negate_mask;
  logic [2:0]      keep_only_mask;

  logic [CW-1:0]   col;
  logic [CW-1:0]   col_next;
  logic            mirror_pend;
  logic            accept;
  logic            last;
  logic [RW_W-1:0] eff_width;

  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;
  logic [CH_W-1:0]   avg;
  pixel_t            grey_px;
  pixel_t            neg_px;
  pixel_t            proc_px;

  function automatic logic [CH_W-1:0] negate(input logic [CH_W-1:0] v,
                                             input logic [CH_W-1:0] cmax);
    return (v > cmax) ? '0 : cmax - v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_limit <= '1;
      row_width <= RW_W'(64);
      grey_enable <= 1'b0;
      mirror_enable <= 1'b0;
      negate_mask <= '0;
      keep_only_mask <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CHAN_LIMIT: chan_limit <= cfg_data;
        CFG_ROW_WIDTH: row_width <= cfg_data[RW_W-1:0];
        CFG_GREY_ENABLE: grey_enable <= cfg_data[0];
        CFG_MIRROR_ENABLE: mirror_enable <= cfg_data[0];
        CFG_NEGATE_MASK: negate_mask <= cfg_data[2:0];
        CFG_KEEP_ONLY_MASK: keep_only_mask <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    sum = SUM_W'(in_data.red_in) + SUM_W'(in_data.green_in) + SUM_W'(in_data.blue_in);
    prod = PROD_W'(sum) * PROD_W'(GREY_RECIP);
    avg = prod[GREY_SHIFT +: CH_W];
    if (grey_enable) begin
      grey_px = '{red: avg, green: avg, blue: avg};
    end else begin
      grey_px = '{red: in_data.red_in, green: in_data.green_in, blue: in_data.blue_in};
    end
    neg_px.red = negate_mask[0] ? negate(grey_px.red, chan_limit) : grey_px.red;
    neg_px.green = negate_mask[1] ? negate(grey_px.green, chan_limit) : grey_px.green;
    neg_px.blue = negate_mask[2] ? negate(grey_px.blue, chan_limit) : grey_px.blue;
    proc_px.red = (|(keep_only_mask & 3'b110)) ? '0 : neg_px.red;
    proc_px.green = (|(keep_only_mask & 3'b101)) ? '0 : neg_px.green;
    proc_px.blue = (|(keep_only_mask & 3'b011)) ? '0 : neg_px.blue;
  end

  always_comb begin
    priority if (row_width == '0) begin
      eff_width = RW_W'(1);
    end else if (row_width > RW_W'(MAX_WIDTH)) begin
      eff_width = RW_W'(MAX_WIDTH);
    end else begin
      eff_width = row_width;
    end
    last = (RW_W'(col) >= eff_width - RW_W'(1));
    col_next = last ? '0 : col + 1'b1;
  end

  assign in_stall = fifo_full || mirror_pend;
  assign accept = in_valid && !in_stall;

  assign push = accept && (!mirror_enable || last);
  assign cmd = '{mirror: mirror_enable, last: last, px: proc_px};
  assign cmd_col = col;

  assign ram_wr_en = accept;
  assign ram_wr_addr = col;
  assign ram_wr_data = proc_px;

  // A pending reversed row blocks input so the line store is not overwritten.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      mirror_pend <= 1'b0;
    end else begin
      if (accept) begin
        col <= col_next;
      end
      if (back_done) begin
        mirror_pend <= 1'b0;
      end else if (push && mirror_enable) begin
        mirror_pend <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rrfm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rrfm_back #(
  parameter int MAX_WIDTH = 64,
  parameter int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  input  wire rrfm_pkg::cmd_t     cmd,
  input  wire logic [CW-1:0]      cmd_col,
  output logic                    pop,
  output logic      [CW-1:0]      ram_rd_addr,
  input  wire rrfm_pkg::pixel_t   ram_rd_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rrfm_pkg::pix_out_t      out_data,
  output logic                    busy,
  output logic                    done
);

  import rrfm_pkg::*;

  back_state_t   state;
  back_state_t   state_next;
  logic [CW-1:0] idx;
  logic          out_free;
  logic          load_direct;
  logic          load_ram;
  logic          start_row;

  assign out_free = !out_valid || !out_stall;
  assign ram_rd_addr = idx;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid && cmd.mirror) begin
          state_next = BK_FETCH;
        end
      end
      BK_FETCH: state_next = BK_WAIT;
      BK_WAIT: begin
        if (out_free) begin
          state_next = (idx == '0) ? BK_IDLE : BK_FETCH;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    start_row = (state == BK_IDLE) && cmd_valid && cmd.mirror;
    load_direct = (state == BK_IDLE) && cmd_valid && !cmd.mirror && out_free;
    load_ram = (state == BK_WAIT) && out_free;
    pop = start_row || load_direct;
    done = load_ram && (idx == '0);
    busy = (state != BK_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_direct || load_ram) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_row) begin
      idx <= cmd_col;
    end else if (load_ram && idx != '0) begin
      idx <= idx - 1'b1;
    end
    if (load_direct) begin
      out_data <= '{red_out: cmd.px.red, green_out: cmd.px.green,
                    blue_out: cmd.px.blue, row_end: cmd.last};
    end else if (load_ram) begin
      out_data <= '{red_out: ram_rd_data.red, green_out: ram_rd_data.green,
                    blue_out: ram_rd_data.blue, row_end: (idx == '0)};
    end
  end

endmodule

`default_nettype wire

// ===== bench/row_filter_checker.sv =====
`timescale 1ns / 1ps

module row_filter_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [rrfm_pkg::IDX_W-1:0]   cfg_index,
  input  logic [rrfm_pkg::CH_W-1:0]    cfg_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  rrfm_pkg::pix_in_t            in_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  rrfm_pkg::pix_out_t           out_data,
  output int                           mismatches,
  output int                           pending
);

  import rrfm_pkg::*;

  localparam int LINE_DEPTH = 64;

  logic [CH_W-1:0] chan_limit;
  logic [RW_W-1:0] row_width;
  logic            grey_on;
  logic            mirror_on;
  logic [2:0]      negate_bits;
  logic [2:0]      keep_bits;

  pixel_t          line_store [LINE_DEPTH];
  logic [RW_W-1:0] column_count;
  pix_out_t        expected_pixels [$];
  int              word_count = 0;

  function automatic logic [CH_W-1:0] negate_channel(logic [CH_W-1:0] v);
    return (chan_limit >= v) ? chan_limit - v : '0;
  endfunction

  function automatic pixel_t filter_pixel(pix_in_t p);
    logic [CH_W+1:0] sum;
    pixel_t q;
    q = pixel_t'{p.red_in, p.green_in, p.blue_in};
    if (grey_on) begin
      sum = {2'b00, q.red} + {2'b00, q.green} + {2'b00, q.blue};
      q.red = CH_W'(sum / 3);
      q.green = q.red;
      q.blue = q.red;
    end
    if (negate_bits[0]) q.red = negate_channel(q.red);
    if (negate_bits[1]) q.green = negate_channel(q.green);
    if (negate_bits[2]) q.blue = negate_channel(q.blue);
    if (keep_bits[1] || keep_bits[2]) q.red = '0;
    if (keep_bits[0] || keep_bits[2]) q.green = '0;
    if (keep_bits[0] || keep_bits[1]) q.blue = '0;
    return q;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%s", msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : track
    int       w;
    int       col;
    pixel_t   px;
    logic     last;
    pix_out_t want;
    if (rst) begin
      chan_limit = 8'd255;
      row_width = 7'd64;
      grey_on = 1'b0;
      mirror_on = 1'b0;
      negate_bits = '0;
      keep_bits = '0;
      column_count = '0;
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CHAN_LIMIT: chan_limit = cfg_data;
          CFG_ROW_WIDTH: row_width = cfg_data[RW_W-1:0];
          CFG_GREY_ENABLE: grey_on = cfg_data[0];
          CFG_MIRROR_ENABLE: mirror_on = cfg_data[0];
          CFG_NEGATE_MASK: negate_bits = cfg_data[2:0];
          CFG_KEEP_ONLY_MASK: keep_bits = cfg_data[2:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        if (row_width == 0) w = 1;
        else if (row_width > LINE_DEPTH) w = LINE_DEPTH;
        else w = int'(row_width);
        col = int'(column_count) % LINE_DEPTH;
        px = filter_pixel(in_data);
        last = (col >= w - 1);
        line_store[col] = px;
        if (mirror_on) begin
          if (last) begin
            for (int i = col; i >= 0; i--) begin
              expected_pixels.push_back(pix_out_t'{line_store[i].red, line_store[i].green,
                                                   line_store[i].blue, i == 0});
            end
          end
        end else begin
          expected_pixels.push_back(pix_out_t'{px.red, px.green, px.blue, last});
        end
        column_count = last ? '0 : RW_W'(col + 1);
      end

      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected output word %0d: %h", word_count, out_data));
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.red_out !== want.red_out)
            report_mismatch($sformatf("word %0d red_out %0d, expected %0d",
                                      word_count, out_data.red_out, want.red_out));
          if (out_data.green_out !== want.green_out)
            report_mismatch($sformatf("word %0d green_out %0d, expected %0d",
                                      word_count, out_data.green_out, want.green_out));
          if (out_data.blue_out !== want.blue_out)
            report_mismatch($sformatf("word %0d blue_out %0d, expected %0d",
                                      word_count, out_data.blue_out, want.blue_out));
          if (out_data.row_end !== want.row_end)
            report_mismatch($sformatf("word %0d row_end %0b, expected %0b",
                                      word_count, out_data.row_end, want.row_end));
        end
        word_count++;
      end
    end
    pending = expected_pixels.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  import rrfm_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE = 16;
  localparam int RANDOM_PIXELS = 80;
  localparam logic [IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CH_W-1:0]  cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  pix_in_t          in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  pix_out_t         out_data;

  int   mismatches;
  int   pending;
  int   cycle_count = 0;
  int   stall_run = 0;
  logic no_gaps = 1'b0;

  rgb_row_filter_with_mirror_top dut (.*);

  row_filter_checker u_check (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Output back-pressure: open stretches, short stalls and the odd long stall.
  always @(posedge clk) begin : out_pacing
    int pick;
    if (stall_run == 0) begin
      pick = $urandom_range(0, 19);
      if (pick < 8) begin
        out_stall <= 1'b0;
        stall_run <= $urandom_range(1, 20);
      end else if (pick < 18) begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(10, 40);
      end
    end else begin
      stall_run <= stall_run - 1;
    end
  end

  function automatic logic [CH_W-1:0] pick_channel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CH_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(logic [CH_W-1:0] cmax, logic [CH_W-1:0] width,
                                logic [CH_W-1:0] grey, logic [CH_W-1:0] mirror,
                                logic [CH_W-1:0] neg, logic [CH_W-1:0] keep);
    write_reg(CFG_CHAN_LIMIT, cmax);
    write_reg(CFG_ROW_WIDTH, width);
    write_reg(CFG_GREY_ENABLE, grey);
    write_reg(CFG_MIRROR_ENABLE, mirror);
    write_reg(CFG_NEGATE_MASK, neg);
    write_reg(CFG_KEEP_ONLY_MASK, keep);
    cfg_valid <= 1'b0;
  endtask

  // Stored pixels of a mirrored row can still be in flight when nothing is pending.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_pixel(pix_in_t p);
    int gap;
    gap = 0;
    if (!no_gaps) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: gap = 0;
        9: gap = $urandom_range(8, 30);
        default: gap = $urandom_range(1, 3);
      endcase
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin : stimulus
    int              sent;
    int              count;
    int              eff_width;
    logic [CH_W-1:0] cmax;
    logic [CH_W-1:0] width;
    logic [CH_W-1:0] keep;
    sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    wait_idle();
    write_reg(CFG_UNUSED_LO, 8'hA5);
    write_reg(CFG_UNUSED_HI, 8'h5A);
    apply_settings(8'd255, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(pix_in_t'{8'd0, 8'd0, 8'd0});
    send_pixel(pix_in_t'{8'd255, 8'd255, 8'd255});
    send_pixel(pix_in_t'{8'h55, 8'hAA, 8'h0F});
    send_pixel(pix_in_t'{8'hAA, 8'h55, 8'hF0});

    // Grey average with full negation; channels above the maximum clamp to zero.
    wait_idle();
    apply_settings(8'd200, 8'd3, 8'd1, 8'd0, 8'd7, 8'd0);
    send_pixel(pix_in_t'{8'd255, 8'd255, 8'd255});
    send_pixel(pix_in_t'{8'd1, 8'd2, 8'd3});
    send_pixel(pix_in_t'{8'd250, 8'd0, 8'd0});

    // A width of zero behaves as one pixel per row.
    wait_idle();
    apply_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd5, 8'd1);
    send_pixel(pix_in_t'{8'd0, 8'd0, 8'd0});
    send_pixel(pix_in_t'{8'd10, 8'd20, 8'd30});

    // An oversized width, then a narrower one that cuts the open row short.
    wait_idle();
    apply_settings(8'd255, 8'd127, 8'd0, 8'd0, 8'd2, 8'd6);
    send_pixel(pix_in_t'{pick_channel(), pick_channel(), pick_channel()});
    send_pixel(pix_in_t'{pick_channel(), pick_channel(), pick_channel()});
    wait_idle();
    write_reg(CFG_ROW_WIDTH, 8'd2);
    cfg_valid <= 1'b0;
    send_pixel(pix_in_t'{pick_channel(), pick_channel(), pick_channel()});

    // Odd-width mirrored row; the middle pixel keeps its position.
    wait_idle();
    apply_settings(8'd255, 8'd5, 8'd0, 8'd1, 8'd0, 8'd0);
    repeat (5) send_pixel(pix_in_t'{pick_channel(), pick_channel(), pick_channel()});

    // Mirroring switched off halfway through a row.
    wait_idle();
    apply_settings(8'd255, 8'd4, 8'd0, 8'd1, 8'd0, 8'd0);
    repeat (2) send_pixel(pix_in_t'{pick_channel(), pick_channel(), pick_channel()});
    wait_idle();
    write_reg(CFG_MIRROR_ENABLE, 8'd0);
    cfg_valid <= 1'b0;
    repeat (2) send_pixel(pix_in_t'{pick_channel(), pick_channel(), pick_channel()});

    // Mirroring switched on halfway through a row.
    wait_idle();
    apply_settings(8'd255, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0);
    repeat (2) send_pixel(pix_in_t'{pick_channel(), pick_channel(), pick_channel()});
    wait_idle();
    write_reg(CFG_MIRROR_ENABLE, 8'd1);
    cfg_valid <= 1'b0;
    repeat (2) send_pixel(pix_in_t'{pick_channel(), pick_channel(), pick_channel()});

    while (sent < RANDOM_PIXELS) begin
      wait_idle();
      case ($urandom_range(0, 3))
        0: cmax = '0;
        1: cmax = '1;
        default: cmax = CH_W'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 9))
        7: width = '0;
        8: width = CH_W'($urandom_range(9, 20));
        9: width = CH_W'($urandom_range(64, 255));
        default: width = CH_W'($urandom_range(1, 8));
      endcase
      eff_width = int'(width[RW_W-1:0]);
      if (eff_width == 0) eff_width = 1;
      if (eff_width > 64) eff_width = 64;
      keep = $urandom_range(0, 1) ? '0 : CH_W'($urandom_range(1, 7));
      if ($urandom_range(0, 7) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_UNUSED_LO : CFG_UNUSED_HI,
                  CH_W'($urandom_range(0, 255)));
      end
      apply_settings(cmax, width, CH_W'($urandom_range(0, 1)), CH_W'($urandom_range(0, 1)),
                     CH_W'($urandom_range(0, 7)), keep);
      if (eff_width > 16) count = eff_width + $urandom_range(0, 2);
      else count = $urandom_range(1, 3 * eff_width + 2);
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (count) send_pixel(pix_in_t'{pick_channel(), pick_channel(), pick_channel()});
      sent += count;
    end

    wait_idle();
    @(negedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
